>>> rtl/ual_pkg.sv
// Shared types and constants for the unordered array list core.
// Depends on nothing; used by rtl/unordered_array_list_core.sv.

package ual_pkg;

  // Default sizing of the list.
  localparam int CAPACITY_DEF   = 64;
  localparam int WORD_WIDTH_DEF = 32;

  // Fixed field widths on the stream ports.
  localparam int ITEM_W   = 32;
  localparam int POS_W    = 6;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // Request modes. Code seven is unused and acts as a no-op.
  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND    = 3'd0,
    MODE_INSERT_AT = 3'd1,
    MODE_DELETE_AT = 3'd2,
    MODE_DELETE_VAL = 3'd3,
    MODE_DELETE_LAST = 3'd4,
    MODE_SEARCH    = 3'd5,
    MODE_CLEAR     = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_MOVE,
    S_INS_PUT,
    S_DEL_MOVE,
    S_SCAN,
    S_RESP
  } state_t;

endpackage

>>> rtl/unordered_array_list_core.sv
// Top level of the unordered array list: request decode, list memory and scan engine.
// Depends on rtl/ual_pkg.sv for modes, status codes, state encoding and defaults.

// The core holds up to CAPACITY signed words in a single-port-write,
// single-port-read synchronous memory plus an entry count, and serves one
// request word at a time: append, insert at a position (the old entry moves
// to the end), delete at a position (the last entry fills the hole), delete
// by value, delete last, search and clear. Order of entries is not kept.
// Each request returns exactly one result word carrying a status, the
// lowest matching index for a successful search and the count after the
// request. Append, delete last, clear and every request rejected at
// decode go straight to the result stage; delete at first reads the last
// entry and writes it into the hole, and insert at reads the old entry,
// moves it to the end and then writes the new word at the position.
// Search and delete by value walk the list through the memory read port one
// entry per cycle; a hit in a delete by value then fills its hole with the last entry.
// A finished result sits in an output register, so the next request word is
// accepted while the previous result still waits for out_tready. The memory
// needs no clearing after reset: only entries below the count are ever read.

module unordered_array_list_core #(
  parameter int CAPACITY   = ual_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = ual_pkg::WORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] item_value, [37:32] position, [39:38] zero
  input  logic [ual_pkg::IN_DATA_W-1:0]    in_tdata,
  // [2:0] mode
  input  logic [ual_pkg::MODE_W-1:0]       in_tuser,
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [5:0] found_index, [12:6] count, [15:13] zero
  output logic [ual_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [2:0] status
  output logic [ual_pkg::STATUS_W-1:0]     out_tuser
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;   // entry index
  localparam int CW = $clog2(CAPACITY + 1);                    // count
  localparam int PW = (CW > ual_pkg::POS_W) ? CW : ual_pkg::POS_W;

  // Request fields.
  logic [ual_pkg::ITEM_W-1:0] in_item;
  logic [ual_pkg::POS_W-1:0]  in_pos;
  ual_pkg::mode_t             in_mode;
  logic [WORD_WIDTH-1:0]      in_word;

  assign in_item = in_tdata[ual_pkg::ITEM_W-1:0];
  assign in_pos  = in_tdata[ual_pkg::ITEM_W +: ual_pkg::POS_W];
  assign in_mode = ual_pkg::mode_t'(in_tuser);
  // The item is sign-extended (or cut) to the stored word width.
  assign in_word = WORD_WIDTH'($signed(in_item));

  // Control and working registers.
  ual_pkg::state_t  state_r, state_nxt;
  ual_pkg::mode_t   mode_r, mode_nxt;
  ual_pkg::status_t status_r, status_nxt;
  logic [WORD_WIDTH-1:0] word_r, word_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         found_r, found_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;

  // Output register.
  logic                          out_tvalid_r, out_tvalid_nxt;
  ual_pkg::status_t              out_status_r;
  logic [ual_pkg::FOUND_W-1:0]   out_found_r;
  logic [ual_pkg::COUNT_W-1:0]   out_count_r;
  logic                          out_load;

  // List memory ports.
  logic [WORD_WIDTH-1:0] mem [CAPACITY];
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [WORD_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [WORD_WIDTH-1:0] rd_data_r;

  // Derived conditions on the request and the count.
  logic list_full;
  logic pos_bad;
  logic scan_hit;

  assign list_full = (count_r == CW'(CAPACITY));
  assign pos_bad   = (PW'(in_pos) >= PW'(count_r));
  // The registered read data belongs to index scan_r - 1 while cmp_vld_r is set.
  assign scan_hit  = cmp_vld_r && (rd_data_r == word_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ual_pkg::S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    status_r  <= status_nxt;
    word_r    <= word_nxt;
    idx_r     <= idx_nxt;
    found_r   <= found_nxt;
    scan_r    <= scan_nxt;
    cmp_vld_r <= cmp_vld_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_found_r  <= ual_pkg::FOUND_W'(found_r);
      out_count_r  <= ual_pkg::COUNT_W'(count_r);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    status_nxt  = status_r;
    word_nxt    = word_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    count_nxt   = count_r;
    scan_nxt    = scan_r;
    cmp_vld_nxt = cmp_vld_r;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = word_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    in_tready   = 1'b0;
    out_load    = 1'b0;

    unique case (state_r)
      ual_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mode_nxt   = in_mode;
          word_nxt   = in_word;
          idx_nxt    = IW'(in_pos);
          status_nxt = ual_pkg::ST_OK;
          found_nxt  = '0;
          state_nxt  = ual_pkg::S_RESP;
          unique case (in_mode)
            ual_pkg::MODE_APPEND: begin
              if (list_full) begin
                status_nxt = ual_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = IW'(count_r);
                wr_data   = in_word;
                count_nxt = count_r + 1'b1;
              end
            end
            ual_pkg::MODE_INSERT_AT: begin
              // Range is checked before fullness.
              if (pos_bad) begin
                status_nxt = ual_pkg::ST_RANGE;
              end else if (list_full) begin
                status_nxt = ual_pkg::ST_FULL;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = IW'(in_pos);
                state_nxt = ual_pkg::S_INS_MOVE;
              end
            end
            ual_pkg::MODE_DELETE_AT: begin
              if (pos_bad) begin
                status_nxt = ual_pkg::ST_RANGE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = IW'(count_r - 1'b1);
                state_nxt = ual_pkg::S_DEL_MOVE;
              end
            end
            ual_pkg::MODE_DELETE_VAL,
            ual_pkg::MODE_SEARCH: begin
              scan_nxt    = '0;
              cmp_vld_nxt = 1'b0;
              state_nxt   = ual_pkg::S_SCAN;
            end
            ual_pkg::MODE_DELETE_LAST: begin
              if (count_r == '0) begin
                status_nxt = ual_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            ual_pkg::MODE_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ual_pkg::S_INS_MOVE: begin
        // Old entry at the position goes to the end of the list.
        wr_en     = 1'b1;
        wr_addr   = IW'(count_r);
        wr_data   = rd_data_r;
        count_nxt = count_r + 1'b1;
        state_nxt = ual_pkg::S_INS_PUT;
      end

      ual_pkg::S_INS_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = word_r;
        state_nxt = ual_pkg::S_RESP;
      end

      ual_pkg::S_DEL_MOVE: begin
        // Last entry fills the hole, then the list shrinks by one.
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_data_r;
        count_nxt = count_r - 1'b1;
        state_nxt = ual_pkg::S_RESP;
      end

      ual_pkg::S_SCAN: begin
        if (scan_hit) begin
          if (mode_r == ual_pkg::MODE_SEARCH) begin
            found_nxt = IW'(scan_r - 1'b1);
            state_nxt = ual_pkg::S_RESP;
          end else begin
            idx_nxt   = IW'(scan_r - 1'b1);
            rd_en     = 1'b1;
            rd_addr   = IW'(count_r - 1'b1);
            state_nxt = ual_pkg::S_DEL_MOVE;
          end
        end else if (scan_r == count_r) begin
          status_nxt = ual_pkg::ST_NOT_FOUND;
          state_nxt  = ual_pkg::S_RESP;
        end else begin
          rd_en       = 1'b1;
          rd_addr     = IW'(scan_r);
          scan_nxt    = scan_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end
      end

      ual_pkg::S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ual_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ual_pkg::S_IDLE;
      end
    endcase

    out_tvalid_nxt = out_load || (out_tvalid_r && !out_tready);
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {
    (ual_pkg::OUT_DATA_W - ual_pkg::COUNT_W - ual_pkg::FOUND_W)'(0),
    out_count_r,
    out_found_r
  };

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ual_pkg::S_SCAN) |-> !wr_en)
    else $error("memory written during a scan");

  a_del_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ual_pkg::S_DEL_MOVE) |-> (count_r != '0))
    else $error("delete move on an empty list");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ual_pkg::S_RESP && status_r == ual_pkg::ST_FULL) |->
      (count_r == CW'(CAPACITY)))
    else $error("full reported while list has room");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ual_pkg::S_INS_MOVE) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the list");
`endif

endmodule

>>> tb/sv/ual_list_checker.sv
// Result checker for the unordered array list core: keeps a shadow copy of the list,
// predicts one result word per accepted request and compares it with the result stream.
// Depends on rtl/ual_pkg.sv for field widths, modes and status codes.

module ual_list_checker
  import ual_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0]     in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [STATUS_W-1:0]   out_tuser,
  output int                    fail_count,
  output int                    waiting,
  output int                    words_checked,
  output logic [COUNT_W-1:0]    model_len
);

  // Index width of the shadow store.
  localparam int SHADOW_IW = $clog2(CAPACITY_DEF);

  typedef struct packed {
    status_t              status;
    logic [FOUND_W-1:0]   found;
    logic [COUNT_W-1:0]   count;
  } list_result_t;

  logic [ITEM_W-1:0]  shadow_words [CAPACITY_DEF];
  logic [COUNT_W-1:0] shadow_len;
  list_result_t       expected_results [$];
  list_result_t       exp_r;
  list_result_t       new_r;
  int                 errors;
  int                 checked;

  function automatic int lowest_match(input logic [ITEM_W-1:0] w);
    for (int i = 0; i < shadow_len; i++) begin
      if (shadow_words[i[SHADOW_IW-1:0]] == w) return i;
    end
    return -1;
  endfunction

  // Swap-on-delete: the last entry fills the hole.
  task automatic drop_entry(input int p);
    logic [COUNT_W-1:0] tail;
    tail = shadow_len - 7'd1;
    shadow_words[p[SHADOW_IW-1:0]] = shadow_words[tail[SHADOW_IW-1:0]];
    shadow_len                     = tail;
  endtask

  task automatic apply_request(input logic [MODE_W-1:0] md, input logic [ITEM_W-1:0] w,
                               input logic [POS_W-1:0] pos, output list_result_t res);
    int idx;
    res.status = ST_OK;
    res.found  = '0;
    case (md)
      MODE_APPEND: begin
        if (shadow_len >= CAPACITY_DEF) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_len[SHADOW_IW-1:0]] = w;
          shadow_len                              = shadow_len + 7'd1;
        end
      end
      MODE_INSERT_AT: begin
        // The range check wins over the full check.
        if (pos >= shadow_len) begin
          res.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY_DEF) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_len[SHADOW_IW-1:0]] = shadow_words[pos];
          shadow_words[pos]                       = w;
          shadow_len                              = shadow_len + 7'd1;
        end
      end
      MODE_DELETE_AT: begin
        if (pos >= shadow_len) res.status = ST_RANGE;
        else drop_entry(pos);
      end
      MODE_DELETE_VAL: begin
        idx = lowest_match(w);
        if (idx < 0) res.status = ST_NOT_FOUND;
        else drop_entry(idx);
      end
      MODE_DELETE_LAST: begin
        if (shadow_len == 0) res.status = ST_EMPTY;
        else shadow_len = shadow_len - 7'd1;
      end
      MODE_SEARCH: begin
        idx = lowest_match(w);
        if (idx < 0) res.status = ST_NOT_FOUND;
        else res.found = idx[FOUND_W-1:0];
      end
      MODE_CLEAR: begin
        shadow_len = '0;
      end
      default: begin
      end
    endcase
    res.count = shadow_len;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_len = '0;
      expected_results.delete();
    end else begin
      // A result always belongs to an earlier request, so retire it first.
      if (out_tvalid && out_tready) begin
        checked++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, actual status %0d data %h",
                   $time, out_tuser, out_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tuser !== exp_r.status) begin
            errors++;
            $display("%0t: status expected %0d, actual %0d", $time, exp_r.status, out_tuser);
          end
          if (out_tdata[5:0] !== exp_r.found) begin
            errors++;
            $display("%0t: found_index expected %0d, actual %0d",
                     $time, exp_r.found, out_tdata[5:0]);
          end
          if (out_tdata[12:6] !== exp_r.count) begin
            errors++;
            $display("%0t: count expected %0d, actual %0d",
                     $time, exp_r.count, out_tdata[12:6]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        apply_request(in_tuser, in_tdata[31:0], in_tdata[37:32], new_r);
        expected_results.push_back(new_r);
      end
    end
    fail_count    <= errors;
    waiting       <= expected_results.size();
    words_checked <= checked;
    model_len     <= shadow_len;
  end

endmodule

>>> tb/sv/unordered_array_list_core_tb.sv
// Top of the unordered array list testbench: clock, reset, request stimulus and verdict.
// Depends on rtl/ual_pkg.sv, rtl/unordered_array_list_core.sv and tb/sv/ual_list_checker.sv.

module unordered_array_list_core_tb;
  import ual_pkg::*;

  // Mode code seven is outside the enum; the core must treat it as a no-op.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  // The slowest correct run is about 1400 requests, stretched by random
  // gaps on both sides. This ceiling is several times that run's length.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1400;
  // Drain time after the last expectation clears: a full-list scan plus margin.
  localparam int DRAIN_CYCLES = CAPACITY_DEF + 16;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // [31:0] item_value, [37:32] position, [39:38] zero
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // [2:0] mode
  logic [MODE_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [5:0] found_index, [12:6] count, [15:13] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  // [2:0] status
  logic [STATUS_W-1:0]   out_tuser;

  int                    fail_count;
  int                    waiting;
  int                    words_checked;
  logic [COUNT_W-1:0]    model_len;

  // Percent chance per cycle that the sender holds off or the receiver stalls.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int cycle_count        = 0;
  int requests_sent      = 0;

  unordered_array_list_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ual_list_checker list_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .waiting       (waiting),
    .words_checked (words_checked),
    .model_len     (model_len)
  );

  always #10 clk = ~clk;

  // Receiver back-pressure and the run watchdog share one clocked process.
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, waiting);
      $display("unordered_array_list_core: mismatch");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
      out_tready  <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Presents one request word and returns at the edge where it is accepted.
  // The valid line is only lowered when a gap is taken, so a back-to-back
  // word never sees a low and a high scheduled in the same step.
  task automatic send_request(input logic [MODE_W-1:0] md, input logic [ITEM_W-1:0] w,
                              input logic [POS_W-1:0] pos);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= md;
    in_tdata  <= {2'b00, pos, w};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Mostly a small pool of values so that duplicates, hits on search and
  // hits on delete by value are common; sometimes the extremes or any word.
  function automatic logic [ITEM_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom();
      default: return 32'($urandom_range(12)) - 32'd6;
    endcase
  endfunction

  // Mode mix depends on whether the list is being pushed toward full or
  // drained toward empty, so both ends of the count are visited often.
  function automatic logic [MODE_W-1:0] pick_mode(input bit growing);
    int r;
    r = $urandom_range(99);
    if (growing) begin
      if (r < 55)      return MODE_APPEND;
      else if (r < 75) return MODE_INSERT_AT;
      else if (r < 80) return MODE_DELETE_AT;
      else if (r < 85) return MODE_DELETE_VAL;
      else if (r < 89) return MODE_DELETE_LAST;
      else if (r < 99) return MODE_SEARCH;
      else             return MODE_UNUSED;
    end else begin
      if (r < 15)      return MODE_APPEND;
      else if (r < 25) return MODE_INSERT_AT;
      else if (r < 45) return MODE_DELETE_AT;
      else if (r < 65) return MODE_DELETE_VAL;
      else if (r < 80) return MODE_DELETE_LAST;
      else if (r < 97) return MODE_SEARCH;
      else if (r < 98) return MODE_CLEAR;
      else             return MODE_UNUSED;
    end
  endfunction

  initial begin
    bit                 growing;
    int                 trend_left;
    int                 pos_lim;
    logic [POS_W-1:0]   pos;

    growing    = 1'b1;
    trend_left = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words with no idling on either side. The list is built up
    // with both extremes and a duplicate, then every mode and the range, not-found
    // and empty rejections are exercised, finishing with delete, insert and search on an empty list.
    send_request(MODE_APPEND,      32'h7FFF_FFFF, 6'd0);
    send_request(MODE_APPEND,      32'h8000_0000, 6'd0);
    send_request(MODE_APPEND,      32'h0000_0000, 6'd0);
    send_request(MODE_APPEND,      32'hFFFF_FFFF, 6'd0);
    send_request(MODE_APPEND,      32'h0000_0000, 6'd0);
    send_request(MODE_SEARCH,      32'h0000_0000, 6'd0);
    send_request(MODE_SEARCH,      32'hFFFF_FFFF, 6'd0);
    send_request(MODE_SEARCH,      32'h0000_0005, 6'd0);
    send_request(MODE_INSERT_AT,   32'h1234_5678, 6'd0);
    // Position equal to the count, then the largest position.
    send_request(MODE_INSERT_AT,   32'h0000_0001, 6'd6);
    send_request(MODE_INSERT_AT,   32'h0000_0001, 6'd63);
    send_request(MODE_DELETE_AT,   32'h0000_0000, 6'd63);
    send_request(MODE_DELETE_AT,   32'h0000_0000, 6'd1);
    send_request(MODE_DELETE_VAL,  32'h0000_0000, 6'd0);
    send_request(MODE_DELETE_VAL,  32'h5555_AAAA, 6'd0);
    send_request(MODE_DELETE_LAST, 32'h0000_0000, 6'd0);
    send_request(MODE_UNUSED,      32'hFFFF_FFFF, 6'd63);
    send_request(MODE_SEARCH,      32'h8000_0000, 6'd0);
    send_request(MODE_CLEAR,       32'h0000_0000, 6'd0);
    send_request(MODE_DELETE_LAST, 32'h0000_0000, 6'd0);
    send_request(MODE_DELETE_AT,   32'h0000_0000, 6'd0);
    send_request(MODE_INSERT_AT,   32'h0000_0007, 6'd0);
    send_request(MODE_SEARCH,      32'h0000_0000, 6'd0);
    send_request(MODE_DELETE_VAL,  32'h0000_0000, 6'd0);

    // Random part. The handshake mix rotates every 175 words so that each
    // setting appears twice, and the list alternates between growing
    // stretches long enough to reach full and draining stretches.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 175) % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
        default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
      endcase
      if (trend_left == 0) begin
        growing    = ~growing;
        trend_left = growing ? $urandom_range(140, 60) : $urandom_range(90, 30);
      end
      trend_left--;
      // Positions mostly land around the live range; some cover all 64.
      pos_lim = (model_len > 7'd62) ? 63 : model_len + 1;
      if ($urandom_range(7) == 0) pos = POS_W'($urandom_range(63));
      else pos = POS_W'($urandom_range(pos_lim));
      send_request(pick_mode(growing), pick_word(), pos);
    end
    in_tvalid <= 1'b0;

    // Let the checker's registered outstanding count catch up with the
    // final word before it is polled.
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request words (directed edge cases, then %0d random) and checked %0d",
             requests_sent, RANDOM_ITEMS, words_checked);
    $display("result words under four sender and receiver idling mixes.");
    if (fail_count == 0) begin
      $display("unordered_array_list_core: match");
    end else begin
      $display("unordered_array_list_core: mismatch");
    end
    $finish;
  end

endmodule
